// ===== rtl/stok_pkg.sv =====
// Package for the source tokenizer: scan modes, token kinds, error codes,
// character classes and the shared front-to-back record. No dependencies.
package stok_pkg;

    localparam int PosBits = 16;
    localparam int LenBits = 8;
    localparam int QueueDepth = 4;
    localparam int QueueAw = 2;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_EQ, M_BANG, M_LT, M_GT, M_AMP, M_BAR,
        M_MINUS, M_INT, M_POINT, M_FRAC, M_IDENT, M_GARBAGE
    } mode_t;

    localparam logic [4:0] K_LPAREN = 5'd0;
    localparam logic [4:0] K_RPAREN = 5'd1;
    localparam logic [4:0] K_LSBRACE = 5'd2;
    localparam logic [4:0] K_RSBRACE = 5'd3;
    localparam logic [4:0] K_LCBRACE = 5'd4;
    localparam logic [4:0] K_RCBRACE = 5'd5;
    localparam logic [4:0] K_COMMA = 5'd6;
    localparam logic [4:0] K_EQUAL = 5'd7;
    localparam logic [4:0] K_EQEQ = 5'd8;
    localparam logic [4:0] K_BANG = 5'd9;
    localparam logic [4:0] K_NOTEQ = 5'd10;
    localparam logic [4:0] K_PLUS = 5'd11;
    localparam logic [4:0] K_MINUS = 5'd12;
    localparam logic [4:0] K_ARROW = 5'd13;
    localparam logic [4:0] K_STAR = 5'd14;
    localparam logic [4:0] K_SLASH = 5'd15;
    localparam logic [4:0] K_LESS = 5'd16;
    localparam logic [4:0] K_LESSEQ = 5'd17;
    localparam logic [4:0] K_GREATER = 5'd18;
    localparam logic [4:0] K_GREATEREQ = 5'd19;
    localparam logic [4:0] K_ANDAND = 5'd20;
    localparam logic [4:0] K_BARBAR = 5'd21;
    localparam logic [4:0] K_INT = 5'd22;
    localparam logic [4:0] K_FLOAT = 5'd23;
    localparam logic [4:0] K_IDENT = 5'd24;
    localparam logic [4:0] K_DEF = 5'd25;
    localparam logic [4:0] K_LET = 5'd26;
    localparam logic [4:0] K_IF = 5'd27;
    localparam logic [4:0] K_ELSE = 5'd28;
    localparam logic [4:0] K_NONE = 5'd31;

    localparam logic [2:0] E_OK = 3'd0;
    localparam logic [2:0] E_AMP = 3'd1;
    localparam logic [2:0] E_BAR = 3'd2;
    localparam logic [2:0] E_FLOAT = 3'd3;
    localparam logic [2:0] E_GARBAGE = 3'd4;

    // One result before its count is attached.
    typedef struct packed {
        logic [4:0]         kind;
        logic [PosBits-1:0] line;
        logic [PosBits-1:0] column;
        logic [LenBits-1:0] length;
        logic [2:0]         error;
        logic               last;
        logic               restart;
    } tok_t;

    // Up to two results caused by one input item.
    typedef struct packed {
        logic second;
        tok_t first_tok;
        tok_t second_tok;
    } entry_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122)
            || is_digit(c) || c == 8'd95;
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        case (c)
            8'h28:   return K_LPAREN;
            8'h29:   return K_RPAREN;
            8'h5B:   return K_LSBRACE;
            8'h5D:   return K_RSBRACE;
            8'h7B:   return K_LCBRACE;
            8'h7D:   return K_RCBRACE;
            8'h2C:   return K_COMMA;
            8'h2B:   return K_PLUS;
            8'h2A:   return K_STAR;
            8'h2F:   return K_SLASH;
            default: return K_NONE;
        endcase
    endfunction

endpackage

// ===== rtl/source_tokenizer.sv =====
// Top level of the source tokenizer: front scanner, result queue and
// output stage. Depends on stok_pkg, stok_front, stok_queue, stok_back.
//
// The block takes one source byte per item on the s_axis channel and sends
// tokens on the m_axis channel. Each input item may cause zero, one or two
// tokens; tlast marks the final token caused by one input item. Setting
// s_axis_tuser (end of input) flushes any pending token and returns the
// scanner, the positions and the token count to their reset values.
// Throughput is one input item per cycle while the queue has room; two
// tokens from one item leave one after the other through the single output
// register. The scanner writes the queue at the accepting edge, and the
// output register loads from the queue once it is free. The queue holds
// four entries, and s_axis_tready falls when fewer than two are free, so
// a stalled receiver backs the input up without loss. After reset the
// block is idle at line 1, column 1, with no tokens counted; nothing is
// lost or repeated however long either side stalls.
module source_tokenizer
    import stok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] char_byte
    input  logic        s_axis_tuser,  // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] token_kind, [20:5] token line, [36:21] start_column,
    // [44:37] token_length, [47:45] error_code, [63:48] token_count
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic   push, pop, not_empty, room, in_fire;
    entry_t entry, head;
    tok_t   tok;
    logic [15:0] cnt;

    assign s_axis_tready = room;
    assign in_fire = s_axis_tvalid && room;

    stok_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_fire), .c(s_axis_tdata),
        .eoi(s_axis_tuser), .push(push), .entry(entry)
    );

    stok_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_entry(entry), .pop(pop),
        .head(head), .not_empty(not_empty), .room(room)
    );

    stok_back u_back (
        .clk(clk), .rst_n(rst_n), .not_empty(not_empty), .head(head), .pop(pop),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_tok(tok),
        .out_count(cnt)
    );

    assign m_axis_tdata = {cnt, tok.error, tok.length, tok.column, tok.line, tok.kind};
    assign m_axis_tlast = tok.last;

endmodule

// ===== rtl/stok_front.sv =====
// Front part of the source tokenizer: scans one byte per cycle while
// in_valid is set, forming up to two results per byte. Depends on stok_pkg.
module stok_front
    import stok_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [7:0]   c,
    input  logic         eoi,
    output logic         push,
    output entry_t       entry
);

    mode_t              mode_reg, mode_next;
    logic [PosBits-1:0] line_reg, line_next, col_reg, col_next;
    logic [PosBits-1:0] sline_reg, sline_next, scol_reg, scol_next;
    logic [LenBits-1:0] len_reg, len_next;
    logic [31:0]        win_reg, win_next;
    logic               halt_reg, halt_next;
    // Set by end of input; the next pushed entry starts the count from zero.
    logic               fresh_reg, fresh_next;

    localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
    localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

    logic [LenBits-1:0] len_grow;
    logic [4:0]         wkind;
    int unsigned        n;
    tok_t               t0, t1;

    assign len_grow = (len_reg < LenMax) ? len_reg + 1'b1 : len_reg;

    always_comb
    begin
        wkind = K_IDENT;
        if (len_reg == LenBits'(3) && win_reg[23:0] == 24'h646566) wkind = K_DEF;
        else if (len_reg == LenBits'(3) && win_reg[23:0] == 24'h6C6574) wkind = K_LET;
        else if (len_reg == LenBits'(2) && win_reg[15:0] == 16'h6966) wkind = K_IF;
        else if (len_reg == LenBits'(4) && win_reg == 32'h656C7365) wkind = K_ELSE;
    end

    always_comb
    begin
        logic       do_start;
        logic [4:0] sk;
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        len_next   = len_reg;
        win_next   = win_reg;
        halt_next  = halt_reg;
        n          = 0;
        t0         = '0;
        t1         = '0;
        do_start   = 1'b0;
        sk         = single_kind(c);

        // Token at the current start position (not yet updated this cycle).
        t0.line   = sline_reg;
        t0.column = scol_reg;

        if (eoi) begin
            if (!halt_reg) begin
                n = 1;
                t0.length = len_reg;
                case (mode_reg)
                    M_EQ:      begin t0.kind = K_EQUAL;   t0.length = LenBits'(1); end
                    M_BANG:    begin t0.kind = K_BANG;    t0.length = LenBits'(1); end
                    M_LT:      begin t0.kind = K_LESS;    t0.length = LenBits'(1); end
                    M_GT:      begin t0.kind = K_GREATER; t0.length = LenBits'(1); end
                    M_MINUS:   begin t0.kind = K_MINUS;   t0.length = LenBits'(1); end
                    M_AMP:     t0.error = E_AMP;
                    M_BAR:     t0.error = E_BAR;
                    M_POINT:   t0.error = E_FLOAT;
                    M_GARBAGE: t0.error = E_GARBAGE;
                    M_INT:     t0.kind = K_INT;
                    M_FRAC:    t0.kind = K_FLOAT;
                    M_IDENT:   t0.kind = wkind;
                    default:   n = 0;
                endcase
            end
            mode_next = M_IDLE; line_next = PosBits'(1); col_next = PosBits'(1);
            sline_next = PosBits'(1); scol_next = PosBits'(1);
            len_next = '0; win_next = '0; halt_next = 1'b0;
        end else begin
            if (!halt_reg) begin
                case (mode_reg)
                    M_COMMENT: if (c == 8'd10) mode_next = M_IDLE;
                    M_EQ, M_BANG, M_LT, M_GT:
                    begin
                        mode_next = M_IDLE;
                        n = 1;
                        if (c == 8'h3D) begin
                            t0.length = LenBits'(2);
                            t0.kind = (mode_reg == M_EQ) ? K_EQEQ :
                                      (mode_reg == M_BANG) ? K_NOTEQ :
                                      (mode_reg == M_LT) ? K_LESSEQ : K_GREATEREQ;
                        end else begin
                            t0.length = LenBits'(1);
                            t0.kind = (mode_reg == M_EQ) ? K_EQUAL :
                                      (mode_reg == M_BANG) ? K_BANG :
                                      (mode_reg == M_LT) ? K_LESS : K_GREATER;
                            do_start = 1'b1;
                        end
                    end
                    M_AMP, M_BAR:
                    begin
                        n = 1;
                        mode_next = M_IDLE;
                        if (c == ((mode_reg == M_AMP) ? 8'h26 : 8'h7C)) begin
                            t0.length = LenBits'(2);
                            t0.kind = (mode_reg == M_AMP) ? K_ANDAND : K_BARBAR;
                        end else begin
                            t0.length = len_reg;
                            t0.error = (mode_reg == M_AMP) ? E_AMP : E_BAR;
                            halt_next = 1'b1;
                        end
                    end
                    M_MINUS:
                        if (is_digit(c)) begin
                            len_next = len_grow; mode_next = M_INT;
                        end else begin
                            mode_next = M_IDLE;
                            n = 1;
                            if (c == 8'h3E) begin
                                t0.kind = K_ARROW; t0.length = LenBits'(2);
                            end else begin
                                t0.kind = K_MINUS; t0.length = LenBits'(1);
                                do_start = 1'b1;
                            end
                        end
                    M_INT:
                        if (is_digit(c)) len_next = len_grow;
                        else if (c == 8'h2E) begin
                            len_next = len_grow; mode_next = M_POINT;
                        end else begin
                            mode_next = M_IDLE; n = 1;
                            t0.kind = K_INT; t0.length = len_reg; do_start = 1'b1;
                        end
                    M_POINT:
                        if (is_digit(c)) begin
                            len_next = len_grow; mode_next = M_FRAC;
                        end else begin
                            n = 1; mode_next = M_IDLE; halt_next = 1'b1;
                            t0.error = E_FLOAT; t0.length = len_reg;
                        end
                    M_FRAC:
                        if (is_digit(c)) len_next = len_grow;
                        else begin
                            mode_next = M_IDLE; n = 1;
                            t0.kind = K_FLOAT; t0.length = len_reg; do_start = 1'b1;
                        end
                    M_IDENT:
                        if (is_word(c)) begin
                            len_next = len_grow; win_next = {win_reg[23:0], c};
                        end else begin
                            mode_next = M_IDLE; n = 1;
                            t0.kind = wkind; t0.length = len_reg; do_start = 1'b1;
                        end
                    M_GARBAGE:
                        if (is_space(c)) begin
                            n = 1; mode_next = M_IDLE; halt_next = 1'b1;
                            t0.error = E_GARBAGE; t0.length = len_reg;
                        end else len_next = len_grow;
                    default: begin mode_next = M_IDLE; do_start = 1'b1; end
                endcase

                if (do_start) begin
                    mode_next = M_IDLE;
                    if (sk != K_NONE || c == 8'h3D || c == 8'h21 || c == 8'h3C
                        || c == 8'h3E || c == 8'h26 || c == 8'h7C || c == 8'h2D
                        || (!is_space(c) && c != 8'h23)) begin
                        sline_next = line_reg; scol_next = col_reg;
                        len_next = LenBits'(1); win_next = {24'd0, c};
                    end
                    case (c)
                        8'h3D: mode_next = M_EQ;
                        8'h21: mode_next = M_BANG;
                        8'h3C: mode_next = M_LT;
                        8'h3E: mode_next = M_GT;
                        8'h26: mode_next = M_AMP;
                        8'h7C: mode_next = M_BAR;
                        8'h2D: mode_next = M_MINUS;
                        8'h23: mode_next = M_COMMENT;
                        default:
                            if (sk != K_NONE) begin
                                if (n == 0) begin
                                    t0 = '0; t0.kind = sk; t0.line = line_reg;
                                    t0.column = col_reg; t0.length = LenBits'(1);
                                end else begin
                                    t1.kind = sk; t1.line = line_reg;
                                    t1.column = col_reg; t1.length = LenBits'(1);
                                end
                                n = n + 1;
                            end else if (is_space(c)) mode_next = M_IDLE;
                            else if (is_digit(c)) mode_next = M_INT;
                            else if (is_word(c)) mode_next = M_IDENT;
                            else mode_next = M_GARBAGE;
                    endcase
                end
            end
            if (c == 8'd10) begin
                if (line_reg < PosMax) line_next = line_reg + 1'b1;
                col_next = PosBits'(1);
            end else if (col_reg < PosMax) col_next = col_reg + 1'b1;
        end
    end

    always_comb
    begin
        entry = '0;
        entry.first_tok = t0;
        entry.second_tok = t1;
        entry.second = (n == 2);
        entry.first_tok.restart = fresh_reg;
        if (n == 2) entry.second_tok.last = 1'b1;
        else entry.first_tok.last = 1'b1;
    end

    assign push = in_valid && (n != 0);

    // A flushed token still belongs to the old source, so the mark is taken
    // after end of input and cleared by the first entry that follows.
    assign fresh_next = eoi ? 1'b1 : ((n != 0) ? 1'b0 : fresh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE; line_reg <= PosBits'(1); col_reg <= PosBits'(1);
            sline_reg <= PosBits'(1); scol_reg <= PosBits'(1);
            len_reg <= '0; win_reg <= '0; halt_reg <= 1'b0; fresh_reg <= 1'b0;
        end else if (in_valid) begin
            mode_reg <= mode_next; line_reg <= line_next; col_reg <= col_next;
            sline_reg <= sline_next; scol_reg <= scol_next;
            len_reg <= len_next; win_reg <= win_next; halt_reg <= halt_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

// ===== rtl/stok_queue.sv =====
// Short queue of result pairs between the front and back parts.
// Depends on stok_pkg.
module stok_queue
    import stok_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   not_empty,
    output logic   room
);

    entry_t              mem_reg [QueueDepth];
    logic [QueueAw-1:0]  wp_reg, rp_reg;
    logic [QueueAw:0]    cnt_reg;

    assign head = mem_reg[rp_reg];
    assign not_empty = cnt_reg != '0;
    // Room for one more entry even if one is pushed this cycle.
    assign room = cnt_reg < (QueueAw+1)'(QueueDepth - 1);

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
        end
    end

endmodule

// ===== rtl/stok_back.sv =====
// Back part of the source tokenizer: splits queue entries into single
// results, attaches the running count and holds the output register.
// Depends on stok_pkg.
module stok_back
    import stok_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         not_empty,
    input  entry_t       head,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output tok_t         out_tok,
    output logic [15:0]  out_count
);

    logic        half_reg;
    logic [15:0] cnt_reg;
    logic        valid_reg;
    tok_t        tok_reg;
    logic [15:0] ocnt_reg;
    logic        load;
    tok_t        cur;
    logic [15:0] base, cnt_new;

    assign cur = half_reg ? head.second_tok : head.first_tok;
    assign load = not_empty && (!valid_reg || out_ready);
    assign pop = load && (half_reg || !head.second);
    // The first entry after end of input begins counting anew.
    assign base = (!half_reg && head.first_tok.restart) ? 16'd0 : cnt_reg;
    assign cnt_new = (base != 16'hFFFF) ? base + 16'd1 : base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            half_reg <= 1'b0; cnt_reg <= '0; valid_reg <= 1'b0;
        end else begin
            if (load) begin
                half_reg <= !pop;
                cnt_reg <= cnt_new;
                valid_reg <= 1'b1;
            end else if (out_ready) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            tok_reg <= cur;
            ocnt_reg <= cnt_new;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok = tok_reg;
    assign out_count = ocnt_reg;

endmodule
